// ===== hdl/msp_fp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_fp_pkg: shared types and constants of the MSP v1 frame parser
// Frame marker characters, verdict codes and the per-byte result record.
// ----------------------------------------------------------------------------
package msp_fp_pkg;

    // Frame marker characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CHAR_M      = 8'h4D;  // 'M'
    localparam logic [7:0] CHAR_LT     = 8'h3C;  // '<' request
    localparam logic [7:0] CHAR_GT     = 8'h3E;  // '>' response

    // Verdict reported with each byte
    typedef enum logic [2:0] {
        ST_BUSY = 3'd0,
        ST_OK   = 3'd1,
        ST_CSUM = 3'd2,
        ST_SIZE = 3'd3,
        ST_HDR  = 3'd4
    } msp_fp_status_t;

    // One result item
    typedef struct packed {
        logic           accepted;
        msp_fp_status_t status;
        logic           payload_valid;
        logic [7:0]     payload_byte;
        logic [5:0]     payload_index;
        logic           direction;
        logic [7:0]     device_id;
        logic [6:0]     data_size;
        logic [7:0]     command;
    } msp_fp_result_t;

endpackage

// ===== hdl/msp_frame_parser.sv =====
// ----------------------------------------------------------------------------
// msp_frame_parser: byte-serial MSP v1 frame parser
// Takes one received byte per transfer and returns one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carry received serial bytes, one per transfer.
//   Every byte yields exactly one transfer on m_valid/m_ready with the parse
//   verdict (m_status), the streamed payload byte and its index when the byte
//   was payload, and the header fields of the current or last frame.
//   A frame is '$' 'M' '<'|'>' id size cmd payload[size] xor. A bad header
//   byte or an oversize length drops back to idle; the checksum byte reports
//   ok or checksum error and returns to idle.
//   Path: the input register holds the byte, the core decodes it, and the
//   result register holds its result. Throughput: one byte per cycle while
//   m_ready keeps up, set by the single decode step between the two registers.
//   Stall: while m_ready is low the result register holds; one more byte
//   waits in the input register, then s_ready drops.
//   Reset (aresetn low, synchronous): both registers empty, parser idle, all
//   header fields and the checksum cleared.
// ----------------------------------------------------------------------------
module msp_frame_parser
    import msp_fp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted,
    output logic [2:0] m_status,
    output logic       m_payload_valid,
    output logic [7:0] m_payload_byte,
    output logic [5:0] m_payload_index,
    output logic       m_direction,
    output logic [7:0] m_device_id,
    output logic [6:0] m_data_size,
    output logic [7:0] m_command
);

    logic           in_vld_reg;
    logic [7:0]     in_byte_reg;
    logic           out_vld_reg;
    msp_fp_result_t out_reg;
    msp_fp_result_t core_result;
    logic           advance;
    logic           step;

    // Move a byte on whenever the result register is free or being taken
    assign advance = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || advance;
    assign step    = in_vld_reg && advance;

    msp_fp_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
        if (step) begin
            out_reg <= core_result;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_accepted      = out_reg.accepted;
    assign m_status        = out_reg.status;
    assign m_payload_valid = out_reg.payload_valid;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_index = out_reg.payload_index;
    assign m_direction     = out_reg.direction;
    assign m_device_id     = out_reg.device_id;
    assign m_data_size     = out_reg.data_size;
    assign m_command       = out_reg.command;

endmodule

// ===== hdl/msp_fp_core.sv =====
// ----------------------------------------------------------------------------
// msp_fp_core: frame state machine of the MSP v1 parser
// Decodes one byte per step, holds the frame header fields and the running
// XOR checksum, and forms the result record for that byte.
// ----------------------------------------------------------------------------
module msp_fp_core
    import msp_fp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic [7:0]     rx_byte,
    output msp_fp_result_t result
);

    localparam logic [7:0] MaxPayload = 8'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_M     = 3'd2,
        PH_ARROW = 3'd3,
        PH_DEV   = 3'd4,
        PH_SIZE  = 3'd5,
        PH_BODY  = 3'd6
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic       dir_reg,    dir_next;
    logic [7:0] dev_reg,    dev_next;
    logic [7:0] size_reg,   size_next;
    logic [7:0] cmd_reg,    cmd_next;
    logic [7:0] offset_reg, offset_next;
    logic [7:0] xor_reg,    xor_next;

    // Decode the byte against the current phase
    always_comb begin
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        dev_next    = dev_reg;
        size_next   = size_reg;
        cmd_next    = cmd_reg;
        offset_next = offset_reg;
        xor_next    = xor_reg;

        result               = '0;
        result.accepted      = 1'b1;
        result.status        = ST_BUSY;

        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == CHAR_DOLLAR) begin
                    phase_next = PH_START;
                end else begin
                    result.accepted = 1'b0;
                end
            end
            PH_START: begin
                if (rx_byte == CHAR_M) begin
                    phase_next = PH_M;
                end else begin
                    phase_next    = PH_IDLE;
                    result.status = ST_HDR;
                end
            end
            PH_M: begin
                if (rx_byte == CHAR_LT || rx_byte == CHAR_GT) begin
                    dir_next   = (rx_byte == CHAR_GT);
                    phase_next = PH_ARROW;
                end else begin
                    phase_next    = PH_IDLE;
                    result.status = ST_HDR;
                end
            end
            PH_ARROW: begin
                dev_next   = rx_byte;
                phase_next = PH_DEV;
            end
            PH_DEV: begin
                // drop frames whose size exceeds the payload limit
                if (rx_byte > MaxPayload) begin
                    phase_next    = PH_IDLE;
                    result.status = ST_SIZE;
                end else begin
                    size_next   = rx_byte;
                    offset_next = '0;
                    xor_next    = rx_byte;
                    phase_next  = PH_SIZE;
                end
            end
            PH_SIZE: begin
                cmd_next   = rx_byte;
                xor_next   = xor_reg ^ rx_byte;
                phase_next = PH_BODY;
            end
            PH_BODY: begin
                if (offset_reg < size_reg) begin
                    // stream the payload byte out with its position
                    xor_next             = xor_reg ^ rx_byte;
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = offset_reg[5:0];
                    offset_next          = offset_reg + 8'd1;
                end else begin
                    // checksum byte closes the frame
                    result.status = (xor_reg == rx_byte) ? ST_OK : ST_CSUM;
                    phase_next    = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        result.direction = dir_next;
        result.device_id = dev_next;
        result.data_size = size_next[6:0];
        result.command   = cmd_next;
    end

    // Hold parser state; advance on each consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            dir_reg    <= 1'b0;
            dev_reg    <= '0;
            size_reg   <= '0;
            cmd_reg    <= '0;
            offset_reg <= '0;
            xor_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
            dev_reg    <= dev_next;
            size_reg   <= size_next;
            cmd_reg    <= cmd_next;
            offset_reg <= offset_next;
            xor_reg    <= xor_next;
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for msp_frame_parser
// Feeds serial bytes through the input channel, first from a short directed
// table, then as random frames (good, bad checksum, broken header, oversize,
// stray bytes). Each byte taken in is run through a local frame parser model,
// and every result transfer is compared field by field with the oldest
// pending expectation. Sender bursts/gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb
    import msp_fp_pkg::*;
();

    localparam int MAX_PAYLOAD   = 64;
    localparam int N_ITEMS       = 1300;
    localparam int PAUSE_AT      = 650;
    localparam int HOLD_AT       = 200;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int N_DIRECTED    = 27;

    // Parser phases of the local model
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_GOT_M,
        PH_GOT_DIR,
        PH_GOT_ID,
        PH_GOT_SIZE,
        PH_BODY
    } parse_phase_t;

    typedef struct {
        logic [7:0]     rx;
        bit             typed;
        msp_fp_result_t want;
    } dir_row_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_accepted;
    logic [2:0] m_status;
    logic       m_payload_valid;
    logic [7:0] m_payload_byte;
    logic [5:0] m_payload_index;
    logic       m_direction;
    logic [7:0] m_device_id;
    logic [6:0] m_data_size;
    logic [7:0] m_command;

    // Local parser state
    parse_phase_t phase_q;
    logic         dir_q;
    logic [7:0]   dev_q;
    logic [7:0]   size_q;
    logic [7:0]   cmd_q;
    logic [7:0]   offset_q;
    logic [7:0]   xsum_q;

    msp_fp_result_t pending_results [$];
    msp_fp_result_t oldest;
    logic [7:0]     frame_q [$];
    dir_row_t       dir_table [N_DIRECTED];

    int  errors       = 0;
    int  bytes_taken  = 0;
    int  result_count = 0;
    int  burst_left   = 0;
    int  idle_cycles  = 0;
    bit  held         = 1'b0;
    bit  paused       = 1'b0;

    msp_frame_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_status       (m_status),
        .m_payload_valid(m_payload_valid),
        .m_payload_byte (m_payload_byte),
        .m_payload_index(m_payload_index),
        .m_direction    (m_direction),
        .m_device_id    (m_device_id),
        .m_data_size    (m_data_size),
        .m_command      (m_command)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic msp_fp_result_t mk_result(
        input logic acc, input msp_fp_status_t st, input logic pv,
        input logic [7:0] pb, input logic [5:0] pi, input logic dir,
        input logic [7:0] dev, input logic [6:0] sz, input logic [7:0] cmd);
        msp_fp_result_t r;
        r.accepted      = acc;
        r.status        = st;
        r.payload_valid = pv;
        r.payload_byte  = pb;
        r.payload_index = pi;
        r.direction     = dir;
        r.device_id     = dev;
        r.data_size     = sz;
        r.command       = cmd;
        return r;
    endfunction

    // Advance the local parser by one byte and return the expected result
    function automatic msp_fp_result_t parse_byte(input logic [7:0] b);
        msp_fp_result_t r;
        r          = '0;
        r.accepted = 1'b1;
        r.status   = ST_BUSY;
        case (phase_q)
            PH_IDLE: begin
                if (b == CHAR_DOLLAR) phase_q = PH_SYNC;
                else r.accepted = 1'b0;
            end
            PH_SYNC: begin
                if (b == CHAR_M) begin
                    phase_q = PH_GOT_M;
                end else begin
                    phase_q  = PH_IDLE;
                    r.status = ST_HDR;
                end
            end
            PH_GOT_M: begin
                if (b == CHAR_LT || b == CHAR_GT) begin
                    dir_q   = (b == CHAR_GT);
                    phase_q = PH_GOT_DIR;
                end else begin
                    phase_q  = PH_IDLE;
                    r.status = ST_HDR;
                end
            end
            PH_GOT_DIR: begin
                dev_q   = b;
                phase_q = PH_GOT_ID;
            end
            PH_GOT_ID: begin
                if (int'(b) > MAX_PAYLOAD) begin
                    phase_q  = PH_IDLE;
                    r.status = ST_SIZE;
                end else begin
                    size_q   = b;
                    offset_q = 8'd0;
                    xsum_q   = b;
                    phase_q  = PH_GOT_SIZE;
                end
            end
            PH_GOT_SIZE: begin
                cmd_q   = b;
                xsum_q  = xsum_q ^ b;
                phase_q = PH_BODY;
            end
            PH_BODY: begin
                if (offset_q < size_q) begin
                    xsum_q          = xsum_q ^ b;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = offset_q[5:0];
                    offset_q        = offset_q + 8'd1;
                end else begin
                    r.status = (xsum_q == b) ? ST_OK : ST_CSUM;
                    phase_q  = PH_IDLE;
                end
            end
            default: phase_q = PH_IDLE;
        endcase
        r.direction = dir_q;
        r.device_id = dev_q;
        r.data_size = size_q[6:0];
        r.command   = cmd_q;
        return r;
    endfunction

    // Queue one random byte sequence: mostly well-formed frames
    function automatic void queue_frame();
        int         kind;
        int         pick;
        logic [7:0] sz;
        logic [7:0] cmd;
        logic [7:0] xs;
        logic [7:0] pb;
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            // stray bytes between frames
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
            return;
        end
        frame_q.push_back(CHAR_DOLLAR);
        if (kind < 72) begin
            frame_q.push_back(CHAR_M);
            frame_q.push_back($urandom_range(0, 1) ? CHAR_GT : CHAR_LT);
            frame_q.push_back(8'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 80) sz = 8'($urandom_range(0, 6));
            else if (pick < 95) sz = 8'($urandom_range(7, 40));
            else sz = 8'($urandom_range(MAX_PAYLOAD - 4, MAX_PAYLOAD));
            cmd = 8'($urandom);
            xs  = sz ^ cmd;
            frame_q.push_back(sz);
            frame_q.push_back(cmd);
            for (int i = 0; i < int'(sz); i++) begin
                pb = 8'($urandom);
                xs = xs ^ pb;
                frame_q.push_back(pb);
            end
            if ($urandom_range(0, 99) < 85) frame_q.push_back(xs);
            else frame_q.push_back(xs ^ 8'($urandom_range(1, 255)));
        end else if (kind < 80) begin
            // broken sync byte
            frame_q.push_back(8'($urandom));
        end else if (kind < 87) begin
            // broken direction byte
            frame_q.push_back(CHAR_M);
            frame_q.push_back(8'($urandom));
        end else begin
            // length above the payload limit
            frame_q.push_back(CHAR_M);
            frame_q.push_back($urandom_range(0, 1) ? CHAR_GT : CHAR_LT);
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        end
    endfunction

    // Offer one byte, hold it until the transfer, then maybe open a gap
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input msp_fp_result_t want);
        msp_fp_result_t pred;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = parse_byte(b);
        pending_results.push_back(typed ? want : pred);
        if (pred.accepted) bytes_taken++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 40);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h",
                     $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Compare each result transfer with the oldest pending expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing pending", $time);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("accepted", 8'(oldest.accepted), 8'(m_accepted));
                check_field("status", 8'(oldest.status), 8'(m_status));
                check_field("payload_valid", 8'(oldest.payload_valid),
                            8'(m_payload_valid));
                check_field("payload_byte", oldest.payload_byte, m_payload_byte);
                check_field("payload_index", 8'(oldest.payload_index),
                            8'(m_payload_index));
                check_field("direction", 8'(oldest.direction), 8'(m_direction));
                check_field("device_id", oldest.device_id, m_device_id);
                check_field("data_size", 8'(oldest.data_size), 8'(m_data_size));
                check_field("command", oldest.command, m_command);
            end
        end
    end

    // Receiver: segments of stall patterns, plus one long hold-off
    initial begin : result_sink
        int mode;
        int seg_len;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 150);
            repeat (seg_len) begin
                @(posedge aclk);
                if (!held && result_count >= HOLD_AT) begin
                    held = 1'b1;
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : byte_source
        phase_q  = PH_IDLE;
        dir_q    = 1'b0;
        dev_q    = 8'h00;
        size_q   = 8'h00;
        cmd_q    = 8'h00;
        offset_q = 8'h00;
        xsum_q   = 8'h00;

        // Directed bytes; typed rows carry a result read straight off the frame rules
        dir_table = '{
            '{8'h00,       1'b1,
              mk_result(1'b0, ST_BUSY, 1'b0, 8'h00, 6'd0, 1'b0, 8'h00, 7'd0, 8'h00)},
            '{8'hFF,       1'b1,
              mk_result(1'b0, ST_BUSY, 1'b0, 8'h00, 6'd0, 1'b0, 8'h00, 7'd0, 8'h00)},
            '{CHAR_DOLLAR, 1'b1,
              mk_result(1'b1, ST_BUSY, 1'b0, 8'h00, 6'd0, 1'b0, 8'h00, 7'd0, 8'h00)},
            // a second '$' is a bad sync byte, not a new start
            '{CHAR_DOLLAR, 1'b1,
              mk_result(1'b1, ST_HDR,  1'b0, 8'h00, 6'd0, 1'b0, 8'h00, 7'd0, 8'h00)},
            '{CHAR_DOLLAR, 1'b0, '0},
            '{CHAR_M,      1'b0, '0},
            // bad direction byte keeps the old direction
            '{8'h41,       1'b1,
              mk_result(1'b1, ST_HDR,  1'b0, 8'h00, 6'd0, 1'b0, 8'h00, 7'd0, 8'h00)},
            '{CHAR_DOLLAR, 1'b0, '0},
            '{CHAR_M,      1'b0, '0},
            '{CHAR_LT,     1'b0, '0},
            '{8'hFF,       1'b0, '0},
            // one above the payload limit
            '{8'h41,       1'b1,
              mk_result(1'b1, ST_SIZE, 1'b0, 8'h00, 6'd0, 1'b0, 8'hFF, 7'd0, 8'h00)},
            // empty response frame: checksum follows the command
            '{CHAR_DOLLAR, 1'b0, '0},
            '{CHAR_M,      1'b0, '0},
            '{CHAR_GT,     1'b0, '0},
            '{8'h00,       1'b0, '0},
            '{8'h00,       1'b0, '0},
            '{8'hFF,       1'b0, '0},
            '{8'hFF,       1'b1,
              mk_result(1'b1, ST_OK,   1'b0, 8'h00, 6'd0, 1'b1, 8'h00, 7'd0, 8'hFF)},
            // one-byte request with a wrong checksum
            '{CHAR_DOLLAR, 1'b0, '0},
            '{CHAR_M,      1'b0, '0},
            '{CHAR_LT,     1'b0, '0},
            '{8'h5A,       1'b0, '0},
            '{8'h01,       1'b0, '0},
            '{8'h80,       1'b0, '0},
            '{8'hAA,       1'b0, '0},
            '{8'h00,       1'b1,
              mk_result(1'b1, ST_CSUM, 1'b0, 8'h00, 6'd0, 1'b0, 8'h5A, 7'd1, 8'h80)}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(dir_table[i].rx, dir_table[i].typed, dir_table[i].want);

        // Random frames; pause once until everything pending has drained
        while (bytes_taken < N_ITEMS) begin
            if (!paused && bytes_taken >= PAUSE_AT) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            queue_frame();
            while (frame_q.size() != 0) send_byte(frame_q.pop_front(), 1'b0, '0);
        end

        // Drop valid and wait for the tail to drain
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
